[src/sac_pkg.sv]
// Package with shared constants and types of the steering align controller.
`default_nettype none
package sac_pkg;

  localparam int FRAC_BITS = 12;
  localparam longint PI_Q30 = 64'd3373259426;
  localparam int PI_FX = int'((PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
  localparam int TWO_PI_FX = 2 * PI_FX;

  localparam int ANGLE_W = 15;
  localparam int SPIN_W = 16;
  localparam int ACCEL_W = 16;
  localparam int RATE_W = 15;
  localparam int RADIUS_W = 14;
  localparam int PROD_W = RATE_W + RADIUS_W;
  localparam int CFG_W = 15;
  localparam int INDEX_W = 3;

  localparam logic [INDEX_W-1:0] REG_MAX_ROTATION = 3'd0;
  localparam logic [INDEX_W-1:0] REG_MAX_SPEED = 3'd1;
  localparam logic [INDEX_W-1:0] REG_TARGET_RADIUS = 3'd2;
  localparam logic [INDEX_W-1:0] REG_SLOW_RADIUS = 3'd3;
  localparam logic [INDEX_W-1:0] REG_TIME_TO_TARGET = 3'd4;

  typedef struct packed {
    logic dead;
    logic use_max;
    logic neg;
    logic signed [SPIN_W-1:0] spin;
  } front_side_t;

  typedef struct packed {
    logic dead;
    logic neg;
    logic zero;
    logic ovf;
  } back_side_t;

endpackage
`default_nettype wire

[src/steering_align_controller.sv]
// Top level of the steering align controller.
// Throughput: one transaction per cycle; the two 15 and 16 stage divider pipelines
// set the depth, and the whole pipeline holds while the output waits.
// Reset clears all valid bits and loads the register defaults.
`default_nettype none
module steering_align_controller (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                wr_en,
  input  wire logic [sac_pkg::INDEX_W-1:0]         wr_index,
  input  wire logic [sac_pkg::CFG_W-1:0]           wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [sac_pkg::ANGLE_W-1:0]  target_angle,
  input  wire logic signed [sac_pkg::ANGLE_W-1:0]  own_angle,
  input  wire logic signed [sac_pkg::SPIN_W-1:0]   own_spin,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [sac_pkg::ACCEL_W-1:0]       angular_accel
);
  import sac_pkg::*;

  localparam int Q2_W = 16;

  logic [RATE_W-1:0]   max_rotation;
  logic [RATE_W-1:0]   max_speed;
  logic [RADIUS_W-1:0] target_radius;
  logic [RADIUS_W-1:0] slow_radius;
  logic [RATE_W-1:0]   time_to_target;

  logic en;

  logic f_valid;
  logic [PROD_W-1:0] f_prod;
  front_side_t f_side;

  logic d1_valid;
  logic [RATE_W-1:0] d1_quot;
  front_side_t d1_side;
  logic [$bits(front_side_t)-1:0] d1_side_raw;

  logic [RATE_W-1:0] speed;
  logic signed [SPIN_W-1:0] wanted;
  logic signed [16:0] err;
  logic [15:0] err_abs;

  logic v3;
  logic [15:0] ae3;
  logic dead3, neg3, zero3;

  logic [FRAC_BITS-1:0] r0;
  logic [Q2_W-1:0] low0;
  back_side_t b_in;
  logic d2_valid;
  logic [Q2_W-1:0] d2_quot;
  back_side_t d2_side;
  logic [$bits(back_side_t)-1:0] d2_side_raw;

  logic [RATE_W-1:0] qm;
  logic signed [ACCEL_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rotation <= RATE_W'(4096);
      max_speed <= RATE_W'(4096);
      target_radius <= RADIUS_W'(819);
      slow_radius <= RADIUS_W'(3072);
      time_to_target <= RATE_W'(410);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MAX_ROTATION: max_rotation <= wr_data;
        REG_MAX_SPEED: max_speed <= wr_data;
        REG_TARGET_RADIUS: target_radius <= wr_data[RADIUS_W-1:0];
        REG_SLOW_RADIUS: slow_radius <= wr_data[RADIUS_W-1:0];
        REG_TIME_TO_TARGET: time_to_target <= wr_data;
        default: ;
      endcase
    end
  end

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  sac_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .target_angle(target_angle), .own_angle(own_angle), .own_spin(own_spin),
    .max_speed(max_speed), .target_radius(target_radius), .slow_radius(slow_radius),
    .out_valid(f_valid), .prod(f_prod), .side(f_side)
  );

  sac_div #(.QW(RATE_W), .DW(RADIUS_W), .SW($bits(front_side_t))) u_div_speed (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid),
    .rem_in(f_side.use_max ? '0 : f_prod[PROD_W-1:RATE_W]),
    .dat_in(f_prod[RATE_W-1:0]), .divisor(slow_radius), .side_in(f_side),
    .out_valid(d1_valid), .quot(d1_quot), .side_out(d1_side_raw)
  );

  assign d1_side = front_side_t'(d1_side_raw);
  assign speed = d1_side.use_max ? max_speed : d1_quot;
  assign wanted = d1_side.neg ? -SPIN_W'(speed) : SPIN_W'(speed);
  assign err = 17'(wanted) - 17'(d1_side.spin);
  assign err_abs = err[16] ? 16'(-err) : 16'(err);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ae3 <= err_abs;
      dead3 <= d1_side.dead;
      neg3 <= err[16];
      zero3 <= err == '0;
    end
  end

  assign r0 = ae3[15:16-FRAC_BITS];
  assign low0 = {ae3[15-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
  assign b_in.dead = dead3;
  assign b_in.neg = neg3;
  assign b_in.zero = zero3;
  assign b_in.ovf = RATE_W'(r0) >= time_to_target;

  sac_div #(.QW(Q2_W), .DW(RATE_W), .SW($bits(back_side_t))) u_div_accel (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .rem_in(b_in.ovf ? '0 : RATE_W'(r0)), .dat_in(low0),
    .divisor(time_to_target), .side_in(b_in),
    .out_valid(d2_valid), .quot(d2_quot), .side_out(d2_side_raw)
  );

  assign d2_side = back_side_t'(d2_side_raw);

  always_comb begin
    if (d2_side.ovf || (d2_quot > Q2_W'(max_rotation))) begin
      qm = max_rotation;
    end else begin
      qm = d2_quot[RATE_W-1:0];
    end
    if (d2_side.dead || d2_side.zero) begin
      acc = '0;
    end else if (d2_side.neg) begin
      acc = -ACCEL_W'(qm);
    end else begin
      acc = ACCEL_W'(qm);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angular_accel <= acc;
    end
  end

`ifndef SYNTHESIS
  a_accel_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angular_accel <= $signed({1'b0, max_rotation}))
      && (angular_accel >= -$signed({1'b0, max_rotation})))
    else $error("Acceleration exceeds the rotation limit.");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready ##1 (out_valid && $stable(angular_accel)))
    else $error("Pending transaction lost or input taken during a stall.");
`endif

endmodule
`default_nettype wire

[src/sac_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module sac_div #(
  parameter int QW = 15,
  parameter int DW = 14,
  parameter int SW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] rem_in,
  input  wire logic [QW-1:0] dat_in,
  input  wire logic [DW-1:0] divisor,
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic [QW-1:0]      quot,
  output logic [SW-1:0]      side_out
);

  logic          v [1:QW];
  logic [DW-1:0] r [1:QW];
  logic [QW-1:0] d [1:QW];
  logic [SW-1:0] s [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic          src_v;
    logic [DW-1:0] src_r;
    logic [QW-1:0] src_d;
    logic [SW-1:0] src_s;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign src_v = in_valid;
      assign src_r = rem_in;
      assign src_d = dat_in;
      assign src_s = side_in;
    end else begin : g_next
      assign src_v = v[k];
      assign src_r = r[k];
      assign src_d = d[k];
      assign src_s = s[k];
    end

    assign t = {src_r, src_d[QW-1]};
    assign ge = t >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[k+1] <= ge ? DW'(t - {1'b0, divisor}) : DW'(t);
        d[k+1] <= {src_d[QW-2:0], ge};
        s[k+1] <= src_s;
      end
    end
  end

  assign out_valid = v[QW];
  assign quot = d[QW];
  assign side_out = s[QW];

endmodule
`default_nettype wire

[src/sac_front.sv]
// Front stages: angle wrap, dead zone and slow zone tests, speed product.
`default_nettype none
module sac_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic                                  in_valid,
  input  wire logic signed [sac_pkg::ANGLE_W-1:0]    target_angle,
  input  wire logic signed [sac_pkg::ANGLE_W-1:0]    own_angle,
  input  wire logic signed [sac_pkg::SPIN_W-1:0]     own_spin,
  input  wire logic [sac_pkg::RATE_W-1:0]            max_speed,
  input  wire logic [sac_pkg::RADIUS_W-1:0]          target_radius,
  input  wire logic [sac_pkg::RADIUS_W-1:0]          slow_radius,
  output logic                                       out_valid,
  output logic [sac_pkg::PROD_W-1:0]                 prod,
  output sac_pkg::front_side_t                       side
);
  import sac_pkg::*;

  logic signed [17:0] d0;
  logic signed [17:0] dw;
  logic signed [ANGLE_W-1:0] diff;
  logic v1;
  logic signed [SPIN_W-1:0] spin1;
  logic [RADIUS_W-1:0] mag;

  assign d0 = 18'(target_angle) - 18'(own_angle) + 18'(PI_FX);

  always_comb begin
    if (d0 < 0) begin
      dw = d0 + 18'(TWO_PI_FX);
    end else if (d0 >= 18'(TWO_PI_FX)) begin
      dw = d0 - 18'(TWO_PI_FX);
    end else begin
      dw = d0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= ANGLE_W'(dw - 18'(PI_FX));
      spin1 <= own_spin;
    end
  end

  assign mag = diff[ANGLE_W-1] ? RADIUS_W'(-diff) : RADIUS_W'(diff);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(max_speed) * PROD_W'(mag);
      side.dead <= mag < target_radius;
      side.use_max <= (slow_radius == '0) || (mag > slow_radius);
      side.neg <= diff[ANGLE_W-1];
      side.spin <= spin1;
    end
  end

endmodule
`default_nettype wire

[sim/steering_align_controller_tb.sv]
// Self-checking testbench for the steering align controller: directed and random stimulus.
`timescale 1ns / 100ps
`default_nettype none
module steering_align_controller_tb;
  import sac_pkg::*;

  localparam int PI_VAL = 12868;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [INDEX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ANGLE_W-1:0] target_angle = '0;
  logic signed [ANGLE_W-1:0] own_angle = '0;
  logic signed [SPIN_W-1:0] own_spin = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ACCEL_W-1:0] angular_accel;

  longint rot_lim, spd_lim, dead_rad, slow_rad, ttt;
  logic signed [ACCEL_W-1:0] accel_queue[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  bit rx_stall_off = 1'b0;

  steering_align_controller u_top (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .target_angle(target_angle),
    .own_angle(own_angle), .own_spin(own_spin), .out_valid(out_valid),
    .out_ready(out_ready), .angular_accel(angular_accel)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [ACCEL_W-1:0] steer_accel(longint tgt, longint own,
                                                            longint spin);
    longint diff, mag, speed, wanted, num, acc;
    diff = (tgt - own + PI_VAL) % (2 * PI_VAL);
    if (diff < 0) diff += 2 * PI_VAL;
    diff -= PI_VAL;
    mag = diff < 0 ? -diff : diff;
    if (mag < dead_rad) return '0;
    if (slow_rad == 0 || mag > slow_rad) speed = spd_lim;
    else speed = (spd_lim * mag) / slow_rad;
    wanted = diff < 0 ? -speed : speed;
    num = (wanted - spin) * (64'sd1 <<< FRAC_BITS);
    if (ttt == 0) acc = num > 0 ? rot_lim : (num < 0 ? -rot_lim : 0);
    else acc = num / ttt;
    if (acc > rot_lim) acc = rot_lim;
    if (acc < -rot_lim) acc = -rot_lim;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc[ACCEL_W-1:0];
  endfunction

  task automatic send_angles(int tgt, int own, int spin);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    target_angle <= tgt[ANGLE_W-1:0];
    own_angle <= own[ANGLE_W-1:0];
    own_spin <= spin[SPIN_W-1:0];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accel_queue.push_back(steer_accel(tgt, own, spin));
    @(negedge clk);
  endtask

  task automatic write_reg(logic [INDEX_W-1:0] idx, int val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val[CFG_W-1:0];
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_MAX_ROTATION: rot_lim = val & 16'h7FFF;
      REG_MAX_SPEED: spd_lim = val & 16'h7FFF;
      REG_TARGET_RADIUS: dead_rad = val & 16'h3FFF;
      REG_SLOW_RADIUS: slow_rad = val & 16'h3FFF;
      default: ttt = val & 16'h7FFF;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (accel_queue.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_config(int rot, int spd, int dead, int slow, int tt);
    drain();
    write_reg(REG_MAX_ROTATION, rot);
    write_reg(REG_MAX_SPEED, spd);
    write_reg(REG_TARGET_RADIUS, dead);
    write_reg(REG_SLOW_RADIUS, slow);
    write_reg(REG_TIME_TO_TARGET, tt);
  endtask

  task automatic send_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0)
        send_angles($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
                    $urandom_range(0, 65535) - 32768);
      else if (r < 3)
        send_angles($urandom_range(0, 2 * PI_VAL - 1) - PI_VAL,
                    $urandom_range(0, 2 * PI_VAL - 1) - PI_VAL,
                    $urandom_range(0, 2000) - 1000);
      else
        send_angles($urandom_range(0, 2 * PI_VAL - 1) - PI_VAL,
                    $urandom_range(0, 2 * PI_VAL - 1) - PI_VAL,
                    $urandom_range(0, 65535) - 32768);
    end
  endtask

  task automatic test_directed();
    send_angles(0, 0, 0);
    send_angles(PI_VAL - 1, -PI_VAL, 0);
    send_angles(-PI_VAL, PI_VAL - 1, 0);
    send_angles(16383, -16384, 32767);
    send_angles(-16384, 16383, -32768);
    send_angles(819, 0, 0);
    send_angles(818, 0, 0);
    send_angles(3072, 0, 100);
    send_angles(0, 3073, -100);
    send_angles(1500, 0, -32768);
    send_angles(-1500, 0, 32767);
    set_config(32767, 32767, 0, 0, 0);
    send_angles(0, 0, 0);
    send_angles(0, 0, 5);
    send_angles(100, 100, -32768);
    send_angles(PI_VAL - 1, 0, 32767);
    set_config(0, 0, 1, 1, 1);
    send_angles(5000, 0, 1234);
    set_config(32767, 32767, 1, 12868, 1);
    send_angles(-4000, 3000, 32767);
    send_angles(4000, -3000, -32768);
  endtask

  task automatic test_random_configs();
    set_config(4096, 4096, 819, 3072, 410);
    send_random(500);
    set_config(32767, 32767, 12868, 12868, 32767);
    send_random(150);
    set_config(1, 0, 1, 1, 1);
    send_random(150);
    for (int k = 0; k < 6; k++) begin
      set_config($urandom_range(1, 32767), $urandom_range(0, 32767), $urandom_range(1, 3000),
                 $urandom_range(1, 12868), $urandom_range(1, 32767));
      send_random(120);
    end
    set_config($urandom_range(1, 8000), $urandom_range(0, 32767), $urandom_range(1, 400),
               $urandom_range(1, 12868), $urandom_range(1, 200));
    rx_stall_off = 1'b1;
    send_random(110);
    rx_stall_off = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (accel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: accel %0d", angular_accel);
      end else begin
        if (angular_accel !== accel_queue[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("accel mismatch: expected %0d actual %0d", accel_queue[0], angular_accel);
        end
        void'(accel_queue.pop_front());
      end
    end
  end

  initial begin : rx_side
    int wait_n;
    @(negedge clk);
    forever begin
      wait_n = rx_stall_off ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n != 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || wr_en) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rot_lim = 4096;
    spd_lim = 4096;
    dead_rad = 819;
    slow_rad = 3072;
    ttt = 410;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_configs();
    drain();
    if (mismatches == 0 && accel_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

[steering_align_controller.f]
src/sac_pkg.sv
src/sac_div.sv
src/sac_front.sv
src/steering_align_controller.sv
sim/steering_align_controller_tb.sv
